### design/sha256_stream_hasher_core_defines.svh
// assertion macros for the sha-256 stream hasher
// used by sha256_stream_hasher_core; expects clk and rst_n in scope
`ifndef SHA256_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA256_STREAM_HASHER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SHS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SHS_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define SHS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define SHS_ASSERT(label, prop, msg)
`define SHS_ASSERT_IMP(label, pre, post, msg)
`define SHS_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

### design/shs_pkg.sv
// shared constants, types and round functions of the sha-256 stream hasher
// no dependencies
package shs_pkg;

  localparam int WORD_W      = 32;
  localparam int CHAIN_DEPTH = 8;
  localparam int CHAIN_AW    = 3;
  localparam int BYTES_W     = 61;

  localparam logic [WORD_W-1:0] MARK_WORD = 32'h8000_0000;

  localparam logic [WORD_W-1:0] IV_WORDS [CHAIN_DEPTH] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WORD_W-1:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic              push;
    logic              expand;
    logic [WORD_W-1:0] word;
  } sched_ctrl_t;

  typedef struct packed {
    logic load;
    logic run;
    logic rotate;
  } round_ctrl_t;

  function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

### design/shs_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module shs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/shs_sched.sv
// 16-word message schedule window with in-place expansion
// depends on shs_pkg
module shs_sched import shs_pkg::*; (
  input  logic              clk,
  input  sched_ctrl_t       ctrl,
  output logic [WORD_W-1:0] w_out
);

  logic [WORD_W-1:0] win_r [16];
  logic [WORD_W-1:0] win_nxt;

  always_comb begin
    if (ctrl.expand) begin
      win_nxt = small_sigma1(win_r[14]) + win_r[9] + small_sigma0(win_r[1]) + win_r[0];
    end else begin
      win_nxt = ctrl.word;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push || ctrl.expand) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[15] <= win_nxt;
    end
  end

  assign w_out = win_r[0];

endmodule

### design/shs_round.sv
// working variables a..h and the sha-256 round function
// depends on shs_pkg
module shs_round import shs_pkg::*; (
  input  logic              clk,
  input  round_ctrl_t       ctrl,
  input  logic [WORD_W-1:0] load_word,
  input  logic [WORD_W-1:0] sched_w,
  input  logic [WORD_W-1:0] round_k,
  output logic [WORD_W-1:0] head_word
);

  // v_r[0] is a, v_r[7] is h
  logic [WORD_W-1:0] v_r [8];
  logic [WORD_W-1:0] t1;
  logic [WORD_W-1:0] t2;
  logic [WORD_W-1:0] ch;
  logic [WORD_W-1:0] maj;

  always_comb begin
    ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1  = v_r[7] + big_sigma1(v_r[4]) + ch + round_k + sched_w;
    t2  = big_sigma0(v_r[0]) + maj;
  end

  always_ff @(posedge clk) begin
    if (ctrl.run) begin
      v_r[0] <= t1 + t2;
      v_r[1] <= v_r[0];
      v_r[2] <= v_r[1];
      v_r[3] <= v_r[2];
      v_r[4] <= v_r[3] + t1;
      v_r[5] <= v_r[4];
      v_r[6] <= v_r[5];
      v_r[7] <= v_r[6];
    end else if (ctrl.load || ctrl.rotate) begin
      for (int i = 0; i < 7; i++) begin
        v_r[i] <= v_r[i+1];
      end
      v_r[7] <= ctrl.load ? load_word : v_r[0];
    end
  end

  assign head_word = v_r[0];

endmodule

### design/sha256_stream_hasher_core.sv
// sha-256 stream hasher top level: message words in, eight digest words out.
// The chaining value lives in an 8-entry ram (valid bits make unwritten entries
// read as the initial hash values); one compression round runs per cycle. The
// word that completes a 16-word block starts a busy phase: the working variables
// are loaded from the ram, 64 rounds run, and the working variables are added
// back and written as the chaining value. After the last word, the padding words
// are pushed (up to 18 of them, with one more block compression when the length
// does not fit in the current block), then the digest leaves at one word per
// cycle while out_stall is low.
// Depends on shs_pkg, shs_ram, shs_sched, shs_round.
`include "sha256_stream_hasher_core_defines.svh"
module sha256_stream_hasher_core import shs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [WORD_W-1:0] in_data_word,
  input  logic [2:0]        in_valid_bytes,
  input  logic              in_last_word,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] out_digest_word,
  output logic [2:0]        out_word_number,
  output logic              out_digest_end
);

  typedef enum logic [2:0] {
    ST_IN,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_WB,
    ST_OUT
  } state_t;

  state_t                   state_r, state_nxt;
  logic [3:0]               slot_r, slot_nxt;
  logic [BYTES_W-1:0]       bytes_r, bytes_nxt;
  logic                     mark_r, mark_nxt;
  logic                     len_hi_r, len_hi_nxt;
  logic                     final_r, final_nxt;
  logic                     ret_pad_r, ret_pad_nxt;
  logic [3:0]               cnt_r, cnt_nxt;
  logic [5:0]               round_r, round_nxt;
  logic [2:0]               out_idx_r, out_idx_nxt;
  logic [CHAIN_DEPTH-1:0]   valid_r, valid_nxt;
  logic [CHAIN_AW-1:0]      rd_q_r;

  logic                     ram_wr_en;
  logic [CHAIN_AW-1:0]      ram_wr_addr;
  logic [WORD_W-1:0]        ram_wr_data;
  logic                     ram_rd_en;
  logic [CHAIN_AW-1:0]      ram_rd_addr;
  logic [WORD_W-1:0]        ram_rd_data;
  logic [WORD_W-1:0]        chain_eff;

  sched_ctrl_t              sched_ctrl;
  round_ctrl_t              round_ctrl;
  logic [WORD_W-1:0]        sched_w;
  logic [WORD_W-1:0]        head_word;

  logic                     push_en;
  logic [WORD_W-1:0]        push_word;
  logic [2:0]               nb_eff;
  logic [WORD_W-1:0]        keep_mask;
  logic [WORD_W-1:0]        tail_mark;
  logic [WORD_W-1:0]        len_hi;
  logic [WORD_W-1:0]        len_lo;

  shs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CHAIN_DEPTH)
  ) u_chain_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  shs_sched u_sched (
    .clk   (clk),
    .ctrl  (sched_ctrl),
    .w_out (sched_w)
  );

  shs_round u_round (
    .clk       (clk),
    .ctrl      (round_ctrl),
    .load_word (chain_eff),
    .sched_w   (sched_w),
    .round_k   (ROUND_K[round_r]),
    .head_word (head_word)
  );

  assign chain_eff   = valid_r[rd_q_r] ? ram_rd_data : IV_WORDS[rd_q_r];
  assign ram_wr_data = chain_eff + head_word;
  assign ram_wr_addr = cnt_r[2:0] - 3'd1;

  assign len_hi = bytes_r[60:29];
  assign len_lo = {bytes_r[28:0], 3'b000};

  // byte count of this transfer, with the last-word mask and 0x80 mark
  always_comb begin
    nb_eff = 3'd4;
    if (in_last_word && (in_valid_bytes < 3'd4)) begin
      nb_eff = in_valid_bytes;
    end
    case (nb_eff)
      3'd0: begin
        keep_mask = 32'h0000_0000;
        tail_mark = 32'h8000_0000;
      end
      3'd1: begin
        keep_mask = 32'hff00_0000;
        tail_mark = 32'h0080_0000;
      end
      3'd2: begin
        keep_mask = 32'hffff_0000;
        tail_mark = 32'h0000_8000;
      end
      3'd3: begin
        keep_mask = 32'hffff_ff00;
        tail_mark = 32'h0000_0080;
      end
      default: begin
        keep_mask = 32'hffff_ffff;
        tail_mark = 32'h0000_0000;
      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    slot_nxt    = slot_r;
    bytes_nxt   = bytes_r;
    mark_nxt    = mark_r;
    len_hi_nxt  = len_hi_r;
    final_nxt   = final_r;
    ret_pad_nxt = ret_pad_r;
    cnt_nxt     = cnt_r;
    round_nxt   = round_r;
    out_idx_nxt = out_idx_r;
    valid_nxt   = valid_r;
    push_en     = 1'b0;
    push_word   = '0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = cnt_r[2:0];
    ram_wr_en   = 1'b0;
    round_ctrl  = '0;

    case (state_r)
      ST_IN: begin
        if (in_valid) begin
          push_en     = 1'b1;
          bytes_nxt   = bytes_r + BYTES_W'(nb_eff);
          ret_pad_nxt = in_last_word;
          if (in_last_word) begin
            state_nxt = ST_PAD;
            mark_nxt  = (nb_eff == 3'd4);
            push_word = (in_data_word & keep_mask) | tail_mark;
          end else begin
            push_word = in_data_word;
          end
        end
      end
      ST_PAD: begin
        push_en = 1'b1;
        if (mark_r) begin
          push_word = MARK_WORD;
          mark_nxt  = 1'b0;
        end else if (len_hi_r) begin
          push_word  = len_lo;
          len_hi_nxt = 1'b0;
          final_nxt  = 1'b1;
        end else if (slot_r == 4'd14) begin
          push_word  = len_hi;
          len_hi_nxt = 1'b1;
        end
      end
      ST_LOAD: begin
        ram_rd_en       = !cnt_r[3];
        round_ctrl.load = (cnt_r != 4'd0);
        if (cnt_r[3]) begin
          state_nxt = ST_ROUND;
          round_nxt = '0;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      ST_ROUND: begin
        round_ctrl.run = 1'b1;
        round_nxt      = round_r + 6'd1;
        if (round_r == 6'd63) begin
          state_nxt = ST_WB;
          cnt_nxt   = '0;
        end
      end
      ST_WB: begin
        ram_rd_en = !cnt_r[3];
        if (cnt_r != 4'd0) begin
          ram_wr_en              = 1'b1;
          round_ctrl.rotate      = 1'b1;
          valid_nxt[ram_wr_addr] = 1'b1;
        end
        if (cnt_r[3]) begin
          if (final_r) begin
            state_nxt   = ST_OUT;
            out_idx_nxt = '0;
            ram_rd_en   = 1'b1;
            ram_rd_addr = '0;
          end else if (ret_pad_r) begin
            state_nxt = ST_PAD;
          end else begin
            state_nxt = ST_IN;
          end
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          if (out_idx_r == 3'd7) begin
            state_nxt   = ST_IN;
            valid_nxt   = '0;
            bytes_nxt   = '0;
            slot_nxt    = '0;
            final_nxt   = 1'b0;
            ret_pad_nxt = 1'b0;
            mark_nxt    = 1'b0;
            len_hi_nxt  = 1'b0;
          end else begin
            out_idx_nxt = out_idx_r + 3'd1;
            ram_rd_en   = 1'b1;
            ram_rd_addr = out_idx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IN;
      end
    endcase

    // a full window starts the compression
    if (push_en) begin
      slot_nxt = slot_r + 4'd1;
      if (slot_r == 4'd15) begin
        state_nxt = ST_LOAD;
        cnt_nxt   = '0;
      end
    end
  end

  assign sched_ctrl.push   = push_en;
  assign sched_ctrl.expand = round_ctrl.run;
  assign sched_ctrl.word   = push_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IN;
      slot_r    <= '0;
      bytes_r   <= '0;
      mark_r    <= 1'b0;
      len_hi_r  <= 1'b0;
      final_r   <= 1'b0;
      ret_pad_r <= 1'b0;
      cnt_r     <= '0;
      round_r   <= '0;
      out_idx_r <= '0;
      valid_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      slot_r    <= slot_nxt;
      bytes_r   <= bytes_nxt;
      mark_r    <= mark_nxt;
      len_hi_r  <= len_hi_nxt;
      final_r   <= final_nxt;
      ret_pad_r <= ret_pad_nxt;
      cnt_r     <= cnt_nxt;
      round_r   <= round_nxt;
      out_idx_r <= out_idx_nxt;
      valid_r   <= valid_nxt;
    end
    if (ram_rd_en) begin
      rd_q_r <= ram_rd_addr;
    end
  end

  assign in_stall        = (state_r != ST_IN);
  assign out_valid       = (state_r == ST_OUT);
  assign out_digest_word = chain_eff;
  assign out_word_number = out_idx_r;
  assign out_digest_end  = (out_idx_r == 3'd7);

  `SHS_ASSERT_NEXT(a_last_round_to_wb, (state_r == ST_ROUND) && (round_r == 6'd63), state_r == ST_WB, "round 63 not followed by writeback")
  `SHS_ASSERT_IMP(a_out_chain_written, state_r == ST_OUT, &valid_r, "digest read before chain fully written")
  `SHS_ASSERT_IMP(a_len_lo_slot, (state_r == ST_PAD) && len_hi_r, slot_r == 4'd15, "low length word off slot 15")
  `SHS_ASSERT_NEXT(a_end_frees_input, out_valid && !out_stall && out_digest_end, !in_stall && (valid_r == '0), "hasher not reset after digest")

endmodule

### sim/testbench.sv
// testbench for sha256_stream_hasher_core: directed vectors, then random messages
// checked against a built-in sha-256 predictor, with random sender and receiver stalls
// depends on shs_pkg and the hasher rtl
`timescale 1ns / 100ps
module testbench import shs_pkg::*; ();

  localparam logic [255:0] EMPTY_DIGEST =
    256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
  localparam logic [255:0] ABC_DIGEST =
    256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;
  localparam logic [WORD_W-1:0] PAD_MARK = 32'h8000_0000;
  localparam int VECTOR_COUNT = 24;
  localparam int PHASE_ITEMS = 72;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TABLE [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [WORD_W-1:0] data;
    logic [2:0]        nbytes;
    logic              last;
    logic              known;
    logic [255:0]      digest;
  } vector_t;

  typedef struct packed {
    logic [WORD_W-1:0] digest_word;
    logic [2:0]        word_number;
    logic              digest_end;
  } digest_entry_t;

  localparam vector_t VECTORS [VECTOR_COUNT] = '{
    '{32'h0000_0000, 3'd0, 1'b1, 1'b1, EMPTY_DIGEST},
    '{32'hffff_ffff, 3'd0, 1'b1, 1'b1, EMPTY_DIGEST},
    '{32'h6162_6300, 3'd3, 1'b1, 1'b1, ABC_DIGEST},
    '{32'h6162_63ff, 3'd3, 1'b1, 1'b1, ABC_DIGEST},
    '{32'h6162_6364, 3'd7, 1'b1, 1'b0, 256'h0},
    '{32'h6162_6364, 3'd4, 1'b1, 1'b0, 256'h0},
    '{32'hffff_ffff, 3'd1, 1'b0, 1'b0, 256'h0},
    '{32'h0000_0000, 3'd2, 1'b1, 1'b0, 256'h0},
    // 64-byte message: padding goes into a block of its own
    '{32'hffff_ffff, 3'd4, 1'b0, 1'b0, 256'h0},
    '{32'h0000_0000, 3'd0, 1'b0, 1'b0, 256'h0},
    '{32'hffff_ffff, 3'd5, 1'b0, 1'b0, 256'h0},
    '{32'h0000_0000, 3'd6, 1'b0, 1'b0, 256'h0},
    '{32'h5a5a_a5a5, 3'd7, 1'b0, 1'b0, 256'h0},
    '{32'ha5a5_5a5a, 3'd2, 1'b0, 1'b0, 256'h0},
    '{32'hffff_ffff, 3'd3, 1'b0, 1'b0, 256'h0},
    '{32'h0000_0000, 3'd4, 1'b0, 1'b0, 256'h0},
    '{32'h0123_4567, 3'd4, 1'b0, 1'b0, 256'h0},
    '{32'h89ab_cdef, 3'd4, 1'b0, 1'b0, 256'h0},
    '{32'hffff_ffff, 3'd4, 1'b0, 1'b0, 256'h0},
    '{32'h0000_0000, 3'd4, 1'b0, 1'b0, 256'h0},
    '{32'hdead_beef, 3'd4, 1'b0, 1'b0, 256'h0},
    '{32'h8000_0001, 3'd4, 1'b0, 1'b0, 256'h0},
    '{32'h7fff_fffe, 3'd4, 1'b0, 1'b0, 256'h0},
    '{32'hffff_ffff, 3'd4, 1'b1, 1'b0, 256'h0}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [WORD_W-1:0] in_data_word = '0;
  logic [2:0]        in_valid_bytes = 3'd0;
  logic              in_last_word = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WORD_W-1:0] out_digest_word;
  logic [2:0]        out_word_number;
  logic              out_digest_end;

  logic [31:0]   hash_state [8];
  logic [31:0]   msg_block [16];
  int unsigned   block_fill;
  logic [60:0]   msg_bytes;
  digest_entry_t digest_queue [$];
  int            mismatches = 0;
  int            send_idle_pct = 0;
  int            stall_pct = 0;

  sha256_stream_hasher_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_word    (in_data_word),
    .in_valid_bytes  (in_valid_bytes),
    .in_last_word    (in_last_word),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_number (out_word_number),
    .out_digest_end  (out_digest_end)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = INIT_HASH[i];
    block_fill = 0;
    msg_bytes = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1;
    logic [31:0] t2;
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        w[r] = msg_block[r];
      end else begin
        w[r] = (ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
             + (ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
      end
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TABLE[r] + w[r];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
  endfunction

  function automatic void absorb_word(input logic [31:0] w);
    msg_block[block_fill] = w;
    block_fill++;
    if (block_fill == 16) begin
      compress_block();
      block_fill = 0;
    end
  endfunction

  // returns 1 when the word closes a message and digest holds the hash
  function automatic logic hash_word(input logic [31:0] data, input logic [2:0] nbytes,
                                     input logic last, output logic [255:0] digest);
    int unsigned n;
    logic [31:0] keep;
    logic [63:0] bit_len;
    digest = '0;
    if (!last) begin
      msg_bytes = msg_bytes + 61'd4;
      absorb_word(data);
      return 1'b0;
    end
    n = (nbytes > 3'd4) ? 4 : nbytes;
    msg_bytes = msg_bytes + 61'(n);
    if (n == 4) begin
      absorb_word(data);
      absorb_word(PAD_MARK);
    end else begin
      keep = ~(32'hffff_ffff >> (8 * n));
      absorb_word((data & keep) | (32'h80 << (24 - 8 * n)));
    end
    while (block_fill != 14) absorb_word(32'h0);
    bit_len = {msg_bytes, 3'b000};
    absorb_word(bit_len[63:32]);
    absorb_word(bit_len[31:0]);
    for (int i = 0; i < 8; i++) digest[255 - 32 * i -: 32] = hash_state[i];
    restart_hash();
    return 1'b1;
  endfunction

  task automatic transfer_word(input logic [31:0] data, input logic [2:0] nbytes,
                               input logic last, input logic known,
                               input logic [255:0] known_digest);
    logic [255:0] digest;
    digest_entry_t entry;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    in_data_word   <= data;
    in_valid_bytes <= nbytes;
    in_last_word   <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (hash_word(data, nbytes, last, digest)) begin
      if (known) digest = known_digest;
      for (int i = 0; i < 8; i++) begin
        entry.digest_word = digest[255 - 32 * i -: 32];
        entry.word_number = 3'(i);
        entry.digest_end  = (i == 7);
        digest_queue.push_back(entry);
      end
    end
  endtask

  task automatic wait_for_digests();
    while (digest_queue.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_digest
    digest_entry_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_queue.size() == 0) begin
        $error("unexpected digest transfer: digest_word %h", out_digest_word);
        mismatches++;
      end else begin
        want = digest_queue.pop_front();
        if (out_digest_word !== want.digest_word) begin
          $error("digest_word: expected %h, actual %h", want.digest_word, out_digest_word);
          mismatches++;
        end
        if (out_word_number !== want.word_number) begin
          $error("word_number: expected %0d, actual %0d", want.word_number, out_word_number);
          mismatches++;
        end
        if (out_digest_end !== want.digest_end) begin
          $error("digest_end: expected %0b, actual %0b", want.digest_end, out_digest_end);
          mismatches++;
        end
      end
    end
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  initial begin
    int phase_items;
    int words;
    int pick;
    logic is_last;
    logic [2:0] nbytes;
    restart_hash();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < VECTOR_COUNT; i++) begin
      transfer_word(VECTORS[i].data, VECTORS[i].nbytes, VECTORS[i].last,
                    VECTORS[i].known, VECTORS[i].digest);
    end
    in_valid <= 1'b0;
    wait_for_digests();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 77;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 77;
        end
        default: begin
          send_idle_pct = 13;
          stall_pct = 13;
        end
      endcase
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        // lengths cluster around block boundaries to hit every padding layout
        pick = $urandom_range(99);
        if (pick < 20) words = $urandom_range(3, 1);
        else if (pick < 75) words = $urandom_range(17, 13);
        else if (pick < 90) words = $urandom_range(33, 29);
        else words = $urandom_range(40, 1);
        if (words > PHASE_ITEMS - phase_items) words = PHASE_ITEMS - phase_items;
        for (int w = 1; w <= words; w++) begin
          is_last = (w == words);
          nbytes = (is_last || $urandom_range(7) == 0) ? 3'($urandom_range(7)) : 3'd4;
          transfer_word($urandom, nbytes, is_last, 1'b0, 256'h0);
        end
        phase_items += words;
      end
      in_valid <= 1'b0;
      wait_for_digests();
    end

    stall_pct = 0;
    repeat (200) @(posedge clk);
    if (mismatches == 0 && digest_queue.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
